// ===== sv/fef_pkg.sv =====
// shared types, constants and helpers for the frequency extreme finder
package fef_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COUNT_WIDTH = 16;
  localparam int VALUE_W     = 32;
  localparam int REPORT_W    = 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

  // request travelling down the chain, with the running winner for a last request
  typedef struct packed {
    logic                          vld;
    logic                          last;
    logic                          placed;
    logic signed [VALUE_W-1:0]     value;
    logic                          best_vld;
    logic signed [VALUE_W-1:0]     best_val;
    logic        [COUNT_WIDTH-1:0] best_cnt;
  } tok_t;

  function automatic logic [REPORT_W-1:0] sat_report(input logic [COUNT_WIDTH-1:0] cnt);
    logic [32:0] wide;
    wide = 33'(cnt);
    if (wide > 33'({REPORT_W{1'b1}})) begin
      return '1;
    end
    return wide[REPORT_W-1:0];
  endfunction

endpackage

// ===== sv/fef_cell.sv =====
// one table entry of the chain: match or claim, then running winner and clear on last
module fef_cell
  import fef_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic sel_least,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic                          ent_vld_r, ent_vld_nxt;
  logic signed [VALUE_W-1:0]     ent_val_r, ent_val_nxt;
  logic        [COUNT_WIDTH-1:0] ent_cnt_r, ent_cnt_nxt;
  tok_t                          tok_r, tok_nxt;

  logic                          hit, claim, upd_vld, take;
  logic signed [VALUE_W-1:0]     upd_val;
  logic        [COUNT_WIDTH-1:0] upd_cnt;

  always_comb begin
    hit   = ent_vld_r && tok_i.vld && !tok_i.placed && (ent_val_r == tok_i.value);
    claim = !ent_vld_r && tok_i.vld && !tok_i.placed;

    upd_vld = ent_vld_r | claim;
    upd_val = claim ? tok_i.value : ent_val_r;
    if (claim) begin
      upd_cnt = COUNT_ONE;
    end else if (hit && ent_cnt_r != COUNT_MAX) begin
      upd_cnt = ent_cnt_r + COUNT_ONE;
    end else begin
      upd_cnt = ent_cnt_r;
    end

    // strict compare keeps the earlier entry on ties
    if (!tok_i.best_vld) begin
      take = upd_vld;
    end else if (sel_least) begin
      take = upd_vld && (upd_cnt < tok_i.best_cnt);
    end else begin
      take = upd_vld && (upd_cnt > tok_i.best_cnt);
    end

    tok_nxt        = tok_i;
    tok_nxt.placed = tok_i.placed | hit | claim;
    if (tok_i.vld && tok_i.last && take) begin
      tok_nxt.best_vld = 1'b1;
      tok_nxt.best_val = upd_val;
      tok_nxt.best_cnt = upd_cnt;
    end

    // the last request of a data set empties the entry behind it
    ent_vld_nxt = (tok_i.vld && tok_i.last) ? 1'b0 : upd_vld;
    ent_val_nxt = upd_val;
    ent_cnt_nxt = upd_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
      tok_r     <= '0;
    end else if (en) begin
      ent_vld_r <= ent_vld_nxt;
      tok_r     <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ent_val_r <= ent_val_nxt;
      ent_cnt_r <= ent_cnt_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== sv/frequency_extreme_finder_unit.sv =====
// top level: chain of table cells, overflow tracking and result register
// Takes one sample per cycle, back to back, through a chain of TABLE_DEPTH cells, each holding
// one distinct value and its count. A sample walks the chain one cell per cycle and is counted
// at the matching cell or stored at the first empty one; a sample that finds no room is dropped
// and flags overflow. The last sample of a data set gathers the most (or least) frequent entry as
// it passes and empties each cell behind it, so the next data set may follow in the very next
// cycle. The result is registered at the output once the last sample has left the last cell. Input
// is held off only while a finished result waits at the output and another one reaches the
// chain's end. Reset empties the table at once; select_least resets to 0 (most frequent).
module frequency_extreme_finder_unit
  import fef_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [VALUE_W-1:0]  in_sample_value,
  input  logic                       in_is_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VALUE_W-1:0]  out_winner_value,
  output logic        [REPORT_W-1:0] out_winner_count,
  output logic                       out_table_overflow
);

  tok_t chain [TABLE_DEPTH+1];
  tok_t head;
  tok_t tail;

  logic                       sel_least_r;
  logic                       ovf_seen_r, ovf_seen_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0]  out_val_r, out_val_nxt;
  logic        [REPORT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                       out_ovf_r, out_ovf_nxt;
  logic                       adv, tail_last;

  always_comb begin
    head          = '0;
    head.vld      = in_valid;
    head.last     = in_is_last;
    head.value    = in_sample_value;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    fef_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .sel_least (sel_least_r),
      .tok_i     (chain[i]),
      .tok_o     (chain[i+1])
    );
  end

  assign tail      = chain[TABLE_DEPTH];
  assign tail_last = tail.vld && tail.last;
  // stall only when a result would land on an untaken one
  assign adv       = !(tail_last && out_valid_r && !out_ready);
  assign in_ready  = adv;

  always_comb begin
    ovf_seen_nxt = ovf_seen_r;
    if (adv && tail.vld) begin
      if (tail.last) begin
        ovf_seen_nxt = 1'b0;
      end else if (!tail.placed) begin
        ovf_seen_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;
    if (adv && tail_last) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = tail.best_val;
      out_cnt_nxt   = sat_report(tail.best_cnt);
      out_ovf_nxt   = ovf_seen_r | !tail.placed;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_least_r <= 1'b0;
      ovf_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sel_least_r <= cfg_wr_data;
      end
      ovf_seen_r  <= ovf_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_winner_value   = out_val_r;
  assign out_winner_count   = out_cnt_r;
  assign out_table_overflow = out_ovf_r;

  a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (tail_last && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while a result is blocked at the chain end");

  a_ovf_cleared : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tail_last) |=> !ovf_seen_r)
    else $error("overflow flag not cleared after a result");

  a_count_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_winner_count != '0))
    else $error("result with zero count");

  a_request_enters : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> chain[1].vld)
    else $error("accepted request missing from the first cell");

endmodule
